FILE: rtl/rgb_tone_curve_mapper_macros.svh
// Assertion helpers shared by the tone curve mapper RTL.
// Each macro expects i_clk and i_rst_n to be visible at the point of use.
`ifndef RGB_TONE_CURVE_MAPPER_MACROS_SVH
`define RGB_TONE_CURVE_MAPPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTCM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rtcm_pkg.sv
`default_nettype none

package rtcm_pkg;

    localparam int CHANNELS = 3;
    localparam int LEVELS   = 256;
    localparam int TOP      = LEVELS - 1;
    localparam int LVL_W    = $clog2(LEVELS);
    localparam int CH_W     = 2;
    localparam int DEPTH    = CHANNELS * LEVELS;
    localparam int ADDR_W   = $clog2(DEPTH);

    // Constants with 16 fraction bits: 1.1 (Q2.16) and 0.8 (Q1.16), and 1/10 scaled by 2^16 for the x1 split.
    localparam logic [17:0] F_BASE   = 18'd72090;
    localparam logic [16:0] CAP_K    = 17'd52429;
    localparam logic [12:0] RECIP10  = 13'd6554;

    localparam int SQRT_STEPS = 21;
    localparam int DIV_STEPS  = 22;

    localparam logic OP_REBUILD = 1'b0;
    localparam logic OP_MAP     = 1'b1;

    localparam logic REG_MIN_GAIN = 1'b0;
    localparam logic REG_MAX_GAIN = 1'b1;

    localparam logic [7:0] MIN_GAIN_RST = 8'd1;
    localparam logic [7:0] MAX_GAIN_RST = 8'd32;

    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_G1, ST_G_R, ST_G_G, ST_G_CAP, ST_G_B, ST_G_END,
        ST_C_D2, ST_C_G2, ST_C_GD, ST_C_GD2, ST_C_E2, ST_C_GE, ST_C_X1, ST_C_GS,
        ST_C_FIN,
        ST_E_SEL, ST_D1, ST_D2, ST_V1, ST_SQRT, ST_V2, ST_DIV, ST_Q_FIN, ST_WR,
        ST_M0, ST_M1, ST_M2, ST_M3
    } t_state;

    // Split point of the dip: floor(3*a/10) by reciprocal multiplication.
    function automatic logic [6:0] f_x1(input logic [7:0] a);
        logic [9:0]  t3;
        logic [22:0] p;
        t3 = {2'b00, a} + {1'b0, a, 1'b0};
        p  = 23'(t3) * 23'(RECIP10);
        return p[22:16];
    endfunction

    // Gain factor 1.1 + (255-a)/255 in Q2.16; 65536 = 255*257 + 1.
    function automatic logic [17:0] f_gain(input logic [7:0] a);
        logic [7:0] m;
        m = 8'(TOP) - a;
        return F_BASE + {2'b00, m, 8'd0} + 18'(m) + 18'(a == 8'd0);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rtcm_if.sv
`default_nettype none

interface rtcm_pix_if import rtcm_pkg::*;;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] chan_red;
    logic [7:0] chan_green;
    logic [7:0] chan_blue;

    modport source (output valid, operation, chan_red, chan_green, chan_blue, input ready);
    modport sink   (input valid, operation, chan_red, chan_green, chan_blue, output ready);
endinterface

interface rtcm_map_if;
    logic       valid;
    logic       ready;
    logic [7:0] mapped_red;
    logic [7:0] mapped_green;
    logic [7:0] mapped_blue;

    modport source (output valid, mapped_red, mapped_green, mapped_blue, input ready);
    modport sink   (input valid, mapped_red, mapped_green, mapped_blue, output ready);
endinterface

interface rtcm_cfg_if;
    logic       valid;
    logic       ready;
    logic       addr;
    logic [7:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/rtcm_ram.sv
`default_nettype none

module rtcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/rgb_tone_curve_mapper.sv
// RGB tone curve mapper.
// Items arrive on i_pix as words. A word with operation set to rebuild carries the three
// channel averages and recomputes all three 256-entry curves in the curve memory; it gives
// no result. A word with operation set to map carries one pixel and gives one word on
// o_map holding the three samples passed through their curves.
// Register min_gain (index 0) and max_gain (index 1) are written on i_cfg, which is always
// ready; write them only while the block is idle.
// A map word passes through states M0 to M3 from acceptance to o_map.valid: three reads of the single
// read port of the curve memory, one per channel.
// A rebuild works out the gains, then the coefficients of each channel, and then each curve
// entry in turn, using the shared multiplier, the 21-step square-root unit and the 22-step divider.
// i_pix.ready is high only while the sequencer is idle, one word is worked on at a time.
// The result sits in an output register: the next word is accepted while it waits, and
// a map word that finishes while o_map is stalled holds until the register frees.
// Synchronous active-low reset returns to idle, drops o_map.valid and restores the
// register defaults; the curve memory is not cleared and must be rebuilt before mapping.
`default_nettype none
`include "rgb_tone_curve_mapper_macros.svh"

module rgb_tone_curve_mapper import rtcm_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rtcm_pix_if.sink    i_pix,
    rtcm_cfg_if.sink    i_cfg,
    rtcm_map_if.source  o_map
);

    t_state r_state, n_state;

    // Configuration registers.
    logic [7:0] r_min_gain, r_max_gain;

    // Rebuild parameters, per channel and shared.
    logic [7:0] r_avg [CHANNELS];
    logic [6:0] r_x1  [CHANNELS];
    logic [7:0] r_x2  [CHANNELS];
    logic [7:0] r_g2  [CHANNELS];
    logic [7:0] r_g1;
    logic [9:0] r_raw;

    // Coefficients of the current curve.
    logic [15:0]        r_d2;
    logic signed [19:0] r_e;
    logic [35:0]        r_k;
    logic [36:0]        r_e2;
    logic [37:0]        r_rb;
    logic signed [27:0] r_ge;
    logic [12:0]        r_q;
    logic [19:0]        r_gs4;

    // Entry sequencing.
    logic [CH_W-1:0]  r_c;
    logic [LVL_W-1:0] r_i;
    logic [7:0]       r_val;
    logic [4:0]       r_cnt;

    // Shared multiplier.
    logic signed [27:0] mul_a;
    logic signed [19:0] mul_b;
    logic signed [47:0] r_prod;

    // Square-root unit.
    logic [41:0] r_sv, r_sr, r_sb;
    logic [41:0] n_sv, n_sr, s_sum;

    // Divider unit.
    logic [21:0] r_dq, n_dq;
    logic [12:0] r_dr, n_dr, r_dd;
    logic [13:0] rem_sh;

    // Map path.
    logic [7:0] r_smp [CHANNELS];
    logic [7:0] r_mr, r_mg;
    logic       r_ov;
    logic [7:0] r_out_r, r_out_g, r_out_b;

    logic              ram_we;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // Values of the current channel.
    logic [6:0]         cx1;
    logic [7:0]         cx2, cg2, dd;
    logic [8:0]         ss;
    logic signed [10:0] two_i_s;
    logic signed [41:0] v_r;
    logic signed [22:0] v_n, s_ext;
    logic               out_free, pix_acc;

    assign cx1      = r_x1[r_c];
    assign cx2      = r_x2[r_c];
    assign cg2      = r_g2[r_c];
    assign dd       = cx2 - {1'b0, cx1};
    assign ss       = {2'b00, cx1} + {1'b0, cx2};
    assign two_i_s  = $signed({2'b00, r_i, 1'b0}) - $signed({2'b00, ss});
    assign v_r      = $signed({4'b0000, r_rb}) + $signed({r_prod[38:0], 3'b000});
    assign s_ext    = $signed({2'b00, r_sr[20:0]});
    assign v_n      = ((r_e > 20'sd0) ? s_ext : -s_ext) - 23'(r_e) + $signed({3'b000, r_gs4});
    assign out_free = !r_ov || o_map.ready;
    assign pix_acc  = i_pix.valid && i_pix.ready;

    assign i_pix.ready        = (r_state == ST_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_map.valid        = r_ov;
    assign o_map.mapped_red   = r_out_r;
    assign o_map.mapped_green = r_out_g;
    assign o_map.mapped_blue  = r_out_b;

    // One square-root step: test the next bit of the root.
    always_comb begin
        s_sum = r_sr + r_sb;
        if (r_sv >= s_sum) begin
            n_sv = r_sv - s_sum;
            n_sr = (r_sr >> 1) + r_sb;
        end else begin
            n_sv = r_sv;
            n_sr = r_sr >> 1;
        end
    end

    // One restoring division step.
    always_comb begin
        rem_sh = {r_dr, r_dq[21]};
        if (rem_sh >= {1'b0, r_dd}) begin
            n_dr = 13'(rem_sh - {1'b0, r_dd});
            n_dq = {r_dq[20:0], 1'b1};
        end else begin
            n_dr = rem_sh[12:0];
            n_dq = {r_dq[20:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state, multiplier operands and memory control.
    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        ram_we  = 1'b0;
        rd_addr = {CH_RED, r_smp[0]};
        unique case (r_state)
            ST_IDLE: begin
                if (i_pix.valid) begin
                    n_state = (i_pix.operation == OP_MAP) ? ST_M0 : ST_G1;
                end
            end
            ST_G1: n_state = ST_G_R;
            ST_G_R: begin
                mul_a   = 28'(f_gain(r_avg[0]));
                mul_b   = 20'(r_g1);
                n_state = ST_G_G;
            end
            ST_G_G: begin
                mul_a   = 28'(f_gain(r_avg[1]));
                mul_b   = 20'(r_g1);
                n_state = ST_G_CAP;
            end
            ST_G_CAP: begin
                mul_a   = 28'(CAP_K);
                mul_b   = 20'(r_g2[0]);
                n_state = ST_G_B;
            end
            ST_G_B: begin
                mul_a   = 28'(f_gain(r_avg[2]));
                mul_b   = 20'(r_g1);
                n_state = ST_G_END;
            end
            ST_G_END: n_state = ST_C_D2;
            ST_C_D2: begin
                mul_a   = 28'(dd);
                mul_b   = 20'(dd);
                n_state = ST_C_G2;
            end
            ST_C_G2: begin
                mul_a   = 28'(cg2);
                mul_b   = 20'(cg2);
                n_state = ST_C_GD;
            end
            ST_C_GD: begin
                mul_a   = 28'(cg2);
                mul_b   = 20'(dd);
                n_state = ST_C_GD2;
            end
            ST_C_GD2: begin
                mul_a   = 28'(r_prod[15:0]);
                mul_b   = 20'(r_prod[15:0]);
                n_state = ST_C_E2;
            end
            ST_C_E2: begin
                mul_a   = 28'(r_e);
                mul_b   = r_e;
                n_state = ST_C_GE;
            end
            ST_C_GE: begin
                mul_a   = 28'(r_e);
                mul_b   = 20'(cg2);
                n_state = ST_C_X1;
            end
            ST_C_X1: begin
                mul_a   = 28'(cx1);
                mul_b   = 20'(cx1);
                n_state = ST_C_GS;
            end
            ST_C_GS: begin
                mul_a   = 28'(ss) + 28'sd1;
                mul_b   = 20'(cg2);
                n_state = ST_C_FIN;
            end
            ST_C_FIN: n_state = ST_E_SEL;
            ST_E_SEL: begin
                if (r_i < 8'(cx1)) begin
                    mul_a   = 28'(r_g1);
                    mul_b   = 20'(r_i);
                    n_state = ST_D1;
                end else if (r_i == 8'(cx1)) begin
                    n_state = ST_WR;
                end else if (r_i < cx2 && cg2 != 8'd0 && r_e != 20'sd0) begin
                    mul_a   = r_ge;
                    mul_b   = 20'(two_i_s);
                    n_state = ST_V1;
                end else begin
                    n_state = ST_WR;
                end
            end
            ST_D1: begin
                mul_a   = 28'(r_prod[15:0]);
                mul_b   = 20'(8'(cx1) - r_i);
                n_state = ST_D2;
            end
            ST_D2: n_state = ST_DIV;
            ST_V1: n_state = v_r[41] ? ST_WR : ST_SQRT;
            ST_SQRT: begin
                if (r_cnt == 5'(SQRT_STEPS - 1)) begin
                    n_state = ST_V2;
                end
            end
            ST_V2: n_state = v_n[22] ? ST_WR : ST_DIV;
            ST_DIV: begin
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    n_state = ST_Q_FIN;
                end
            end
            ST_Q_FIN: n_state = ST_WR;
            ST_WR: begin
                ram_we = 1'b1;
                if (r_i == LVL_W'(TOP)) begin
                    n_state = (r_c == CH_BLUE) ? ST_IDLE : ST_C_D2;
                end else begin
                    n_state = ST_E_SEL;
                end
            end
            ST_M0: begin
                rd_addr = {CH_RED, r_smp[0]};
                n_state = ST_M1;
            end
            ST_M1: begin
                rd_addr = {CH_GREEN, r_smp[1]};
                n_state = ST_M2;
            end
            ST_M2: begin
                rd_addr = {CH_BLUE, r_smp[2]};
                n_state = ST_M3;
            end
            ST_M3: begin
                rd_addr = {CH_BLUE, r_smp[2]};
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gain <= MIN_GAIN_RST;
            r_max_gain <= MAX_GAIN_RST;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.addr == REG_MIN_GAIN) begin
                    r_min_gain <= i_cfg.data;
                end else begin
                    r_max_gain <= i_cfg.data;
                end
            end
            if (r_state == ST_M3 && out_free) begin
                r_ov <= 1'b1;
            end else if (o_map.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            ST_IDLE: begin
                if (pix_acc) begin
                    r_smp[0] <= i_pix.chan_red;
                    r_smp[1] <= i_pix.chan_green;
                    r_smp[2] <= i_pix.chan_blue;
                    r_avg[0] <= i_pix.chan_red;
                    r_avg[1] <= i_pix.chan_green;
                    r_avg[2] <= i_pix.chan_blue;
                    r_x1[0]  <= f_x1(i_pix.chan_red);
                    r_x1[1]  <= f_x1(i_pix.chan_green);
                    r_x1[2]  <= f_x1(i_pix.chan_blue);
                    r_x2[0]  <= i_pix.chan_red + ((8'(TOP) - i_pix.chan_red) >> 1);
                    r_x2[1]  <= i_pix.chan_green + ((8'(TOP) - i_pix.chan_green) >> 1);
                    r_x2[2]  <= i_pix.chan_blue + ((8'(TOP) - i_pix.chan_blue) >> 1);
                end
            end
            ST_G1: begin
                r_g1 <= ({5'd0, r_x1[0][6:3]} < r_min_gain) ? r_min_gain
                                                              : {4'd0, r_x1[0][6:3]};
            end
            ST_G_G: begin
                r_g2[0] <= (r_prod[25:16] > {2'b00, r_max_gain}) ? r_max_gain
                                                                  : r_prod[23:16];
            end
            ST_G_CAP: r_raw <= r_prod[25:16];
            ST_G_B: begin
                r_g2[1] <= (r_raw > {2'b00, r_prod[23:16]}) ? r_prod[23:16] : r_raw[7:0];
            end
            ST_G_END: begin
                r_g2[2] <= (r_prod[25:16] > {2'b00, r_g2[0]}) ? r_g2[0] : r_prod[23:16];
                r_c     <= CH_RED;
            end
            ST_C_G2: r_d2 <= r_prod[15:0];
            ST_C_GD: begin
                r_e <= $signed({4'b0000, r_d2}) - $signed({2'b00, r_prod[15:0], 2'b00});
            end
            ST_C_E2: r_k  <= {r_prod[31:0], 4'b0000};
            ST_C_GE: r_e2 <= r_prod[36:0];
            ST_C_X1: r_ge <= r_prod[27:0];
            ST_C_GS: r_q  <= r_prod[12:0];
            ST_C_FIN: begin
                r_gs4 <= {r_prod[17:0], 2'b00};
                r_rb  <= 38'(r_e2) + 38'(r_k);
                r_i   <= '0;
            end
            ST_E_SEL: begin
                r_val <= (r_i == 8'(cx1)) ? 8'(cx1) : r_i;
            end
            ST_D2: begin
                r_dq  <= 22'({r_prod[18:0], 2'b00}) + 22'(r_q) - 22'd1;
                r_dd  <= r_q;
                r_dr  <= '0;
                r_cnt <= '0;
            end
            ST_V1: begin
                r_sv  <= v_r[41:0];
                r_sr  <= '0;
                r_sb  <= 42'd1 << (2 * (SQRT_STEPS - 1));
                r_cnt <= '0;
            end
            ST_SQRT: begin
                r_sv  <= n_sv;
                r_sr  <= n_sr;
                r_sb  <= r_sb >> 2;
                r_cnt <= r_cnt + 5'd1;
            end
            ST_V2: begin
                r_val <= 8'd0;
                r_dq  <= v_n[21:0];
                r_dd  <= {2'b00, cg2, 3'b000};
                r_dr  <= '0;
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_dq  <= n_dq;
                r_dr  <= n_dr;
                r_cnt <= r_cnt + 5'd1;
            end
            ST_Q_FIN: begin
                if (r_i < 8'(cx1)) begin
                    r_val <= (r_dq > 22'(r_i)) ? 8'd0 : r_i - r_dq[7:0];
                end else begin
                    r_val <= (r_dq > 22'(TOP)) ? 8'(TOP) : r_dq[7:0];
                end
            end
            ST_WR: begin
                if (r_i == LVL_W'(TOP)) begin
                    r_c <= r_c + 2'd1;
                end else begin
                    r_i <= r_i + 8'd1;
                end
            end
            ST_M1: r_mr <= rd_data;
            ST_M2: r_mg <= rd_data;
            ST_M3: begin
                if (out_free) begin
                    r_out_r <= r_mr;
                    r_out_g <= r_mg;
                    r_out_b <= rd_data;
                end
            end
            default: begin
            end
        endcase
    end

    rtcm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_curve_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({r_c, r_i}),
        .i_wdata (r_val),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    `RTCM_ASSERT_NEXT(a_map_starts_read, pix_acc && i_pix.operation == OP_MAP, r_state == ST_M0 && !i_pix.ready, "map word did not start the curve reads")
    `RTCM_ASSERT_NOW(a_result_from_read, $rose(r_ov), $past(r_state) == ST_M3, "result raised outside the last read step")
    `RTCM_ASSERT_NOW(a_gain_caps, r_state == ST_C_D2, r_g2[1] <= r_g2[0] && r_g2[2] <= r_g2[0], "green or blue gain above red gain")
    `RTCM_ASSERT_NOW(a_div_nonzero, r_state == ST_DIV, r_dd != 13'd0, "divider running with zero divisor")
    `RTCM_ASSERT_NOW(a_write_channel, r_state == ST_WR, r_c <= CH_BLUE, "curve write beyond the last channel")

endmodule

`default_nettype wire
